/* rtl/core/box_avg_pkg.sv */
// Shared types and constants for the box-average downscaler.
// No dependencies; every other file but box_avg_ram imports this package.
`default_nettype none

package box_avg_pkg;

  // Pixel channel width and channel count.
  localparam int PIX_W  = 8;
  localparam int NUM_CH = 3;

  // Configuration register widths as seen on the write port.
  localparam int SCALE_W    = 5;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Result queue depth and the number of pipeline stages ahead of it.
  localparam int FIFO_DEPTH  = 8;
  localparam int PIPE_STAGES = 3;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_FACTOR = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_idx_t;

  // One input pixel.
  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } pix_t;

  // One downscaled output pixel.
  typedef struct packed {
    logic [PIX_W-1:0] red_mean;
    logic [PIX_W-1:0] green_mean;
    logic [PIX_W-1:0] blue_mean;
    logic             frame_end;
  } res_t;

  // Control that travels with a finished block sum into the mean unit.
  typedef struct packed {
    logic valid;
    logic frame_end;
  } mean_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/box_avg_ifs.sv */
// Stream interfaces for the pixel input and the result output.
// Depends on box_avg_pkg for the payload structs.
`default_nettype none

interface box_avg_pix_if import box_avg_pkg::*; ();
  logic valid;
  logic ready;
  pix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface box_avg_res_if import box_avg_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/box_avg_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module box_avg_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/box_avg_mean.sv */
// Two-stage mean unit: divides each channel's block sum by factor squared.
// Depends on box_avg_pkg; uses a reciprocal table built at elaboration.
`default_nettype none

module box_avg_mean
  import box_avg_pkg::*;
#(
  parameter int MAX_FACTOR = 16
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic [$clog2(MAX_FACTOR+1)-1:0]                    factor,
  input  mean_ctl_t                                          req,
  input  logic [NUM_CH-1:0][PIX_W+2*$clog2(MAX_FACTOR)-1:0]  sums,
  output logic                                               res_valid,
  output res_t                                               res
);

  localparam int SUM_W = PIX_W + 2 * $clog2(MAX_FACTOR);
  // Reciprocal scale: exact floor division for every sum below 2**SUM_W.
  localparam int K     = SUM_W + 2 * $clog2(MAX_FACTOR);
  localparam int PW    = SUM_W + K + 1;

  logic [K:0] recip_tbl [MAX_FACTOR+1];

  // Reciprocal of factor squared, rounded up, for every factor.
  for (genvar g = 0; g <= MAX_FACTOR; g++) begin : g_recip
    localparam int unsigned DIV_I = (g == 0) ? 1 : g * g;
    localparam logic [K+1:0] POW  = (K+2)'(1) << K;
    localparam logic [K+1:0] DIV  = (K+2)'(DIV_I);
    localparam logic [K+1:0] RCP  = (POW + DIV - (K+2)'(1)) / DIV;
    assign recip_tbl[g] = RCP[K:0];
  end

  logic                              s2_v_r;
  logic                              s2_fend_r;
  logic [NUM_CH-1:0][SUM_W-1:0]      s2_sum_r;
  logic [K:0]                        s2_rcp_r;
  logic [PW-1:0]                     prod [NUM_CH];
  logic [NUM_CH-1:0][PIX_W-1:0]      mean;
  logic                              s3_v_r;
  res_t                              s3_res_r;

  // Stage two: capture the sums and look up the reciprocal.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= req.valid;
    end
    if (req.valid) begin
      s2_fend_r <= req.frame_end;
      s2_sum_r  <= sums;
      s2_rcp_r  <= recip_tbl[factor];
    end
  end

  // One multiplier per channel; the quotient sits above the fraction bits.
  for (genvar c = 0; c < NUM_CH; c++) begin : g_mul
    assign prod[c] = PW'(s2_sum_r[c]) * PW'(s2_rcp_r);
    assign mean[c] = prod[c][K+PIX_W-1:K];
  end

  // Stage three: register the means.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
    if (s2_v_r) begin
      s3_res_r.red_mean   <= mean[0];
      s3_res_r.green_mean <= mean[1];
      s3_res_r.blue_mean  <= mean[2];
      s3_res_r.frame_end  <= s2_fend_r;
    end
  end

  assign res_valid = s3_v_r;
  assign res       = s3_res_r;

endmodule

`default_nettype wire

/* rtl/core/box_average_downscaler_top.sv */
// Box-average downscaler. Takes RGB888 pixels in raster order and emits one
// pixel per whole scale_factor x scale_factor block, each channel the block
// sum divided by the factor squared and truncated. Partial blocks at the
// right and bottom edges are dropped. One pixel is accepted per clock for as
// long as the result queue has room; each result passes the read-modify-write
// stage and the mean unit before it is written to the output queue. Per-column
// sums live in one RAM of MAX_WIDTH entries with a registered read; the block
// reads an entry when a pixel is accepted and, for a pixel of a whole block,
// writes it back in the next cycle, forwarding the last write when the next
// pixel hits the same column. Acceptance pauses while more than FIFO_DEPTH
// minus four results are queued. No clearing pass: a block's first pixel
// ignores the old entry. A write to a defined register restarts the frame.
// Depends on box_avg_pkg, box_avg_ifs, box_avg_ram and box_avg_mean.
`default_nettype none

module box_average_downscaler_top
  import box_avg_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_FACTOR = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  box_avg_pix_if.sink           in_pix,
  box_avg_res_if.source         out_res
);

  localparam int AW      = $clog2(MAX_WIDTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int CW      = $clog2(MAX_WIDTH + MAX_FACTOR + 1);
  localparam int FW      = $clog2(MAX_FACTOR + 1);
  localparam int BW      = $clog2(MAX_FACTOR);
  localparam int HW      = HEIGHT_W;
  localparam int RW      = HEIGHT_W + 1;
  localparam int SUM_W   = PIX_W + 2 * BW;
  localparam int RAM_W   = NUM_CH * SUM_W;
  localparam int FAW     = $clog2(FIFO_DEPTH);
  localparam int FCW     = $clog2(FIFO_DEPTH + 1);
  localparam int W_RESET = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
  localparam int ACCEPT_LIMIT = FIFO_DEPTH - PIPE_STAGES - 1;

  // Effective configuration.
  logic [FW-1:0] f_r, f_nxt;
  logic [WW-1:0] w_r, w_nxt;
  logic [HW-1:0] h_r, h_nxt;
  logic          cfg_hit;

  // Raster position.
  logic [AW-1:0] cc_r, cc_nxt;
  logic [HW-1:0] rc_r, rc_nxt;
  logic [BW-1:0] cib_r, cib_nxt;
  logic [BW-1:0] rib_r, rib_nxt;
  logic [AW-1:0] oc_r, oc_nxt;
  logic [AW-1:0] col_start_r, col_start_nxt;
  logic [HW-1:0] row_start_r, row_start_nxt;

  // Decode of the current position.
  logic acc;
  logic in_cols, in_rows, active;
  logic col_tail_ok, row_tail_ok;
  logic cib_end, rib_end, first, last;
  logic row_end, frame_wrap;
  logic frame_end;

  // Read-modify-write stage.
  logic                          s1_v_r;
  logic                          s1_act_r;
  logic                          s1_first_r;
  logic                          s1_last_r;
  logic                          s1_fend_r;
  logic [AW-1:0]                 s1_addr_r;
  pix_t                          s1_pix_r;
  logic [NUM_CH-1:0][SUM_W-1:0]  ram_rdata;
  logic [NUM_CH-1:0][SUM_W-1:0]  base;
  logic [NUM_CH-1:0][SUM_W-1:0]  new_sum;
  logic [NUM_CH-1:0][PIX_W-1:0]  s1_ch;
  logic                          wr_en;
  logic                          lw_v_r;
  logic [AW-1:0]                 lw_addr_r;
  logic [NUM_CH-1:0][SUM_W-1:0]  lw_data_r;

  // Mean unit and result queue.
  mean_ctl_t     mean_req;
  logic          mres_valid;
  res_t          mres;
  res_t          fifo_mem_r [FIFO_DEPTH];
  logic [FAW-1:0] wp_r, rp_r;
  logic [FCW-1:0] cnt_r, cnt_nxt;
  logic           push, pop;

  assign acc          = in_pix.valid && in_pix.ready;
  assign in_pix.ready = (cnt_r <= FCW'(ACCEPT_LIMIT));

  // Configuration decode with the clamping of out-of-range values.
  always_comb begin
    logic [SCALE_W-1:0] sv;
    logic [WIDTH_W-1:0] wv;
    logic [HW-1:0]      hv;
    sv      = cfg_data[SCALE_W-1:0];
    wv      = cfg_data[WIDTH_W-1:0];
    hv      = cfg_data[HW-1:0];
    f_nxt   = f_r;
    w_nxt   = w_r;
    h_nxt   = h_r;
    cfg_hit = 1'b0;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SCALE_FACTOR: begin
          cfg_hit = 1'b1;
          if (sv == '0) begin
            f_nxt = FW'(1);
          end else if (int'(sv) > MAX_FACTOR) begin
            f_nxt = FW'(MAX_FACTOR);
          end else begin
            f_nxt = FW'(sv);
          end
        end
        CFG_IMAGE_WIDTH: begin
          cfg_hit = 1'b1;
          if (wv == '0) begin
            w_nxt = WW'(1);
          end else if (int'(wv) > MAX_WIDTH) begin
            w_nxt = WW'(MAX_WIDTH);
          end else begin
            w_nxt = WW'(wv);
          end
        end
        CFG_IMAGE_HEIGHT: begin
          cfg_hit = 1'b1;
          h_nxt   = (hv == '0) ? HW'(1) : hv;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // A block is whole when its start plus the factor stays inside the image.
  assign in_cols     = (CW'(col_start_r) + CW'(f_r)) <= CW'(w_r);
  assign in_rows     = (RW'(row_start_r) + RW'(f_r)) <= RW'(h_r);
  assign col_tail_ok = (CW'(cc_r) + CW'(f_r)) < CW'(w_r);
  assign row_tail_ok = (RW'(rc_r) + RW'(f_r)) < RW'(h_r);
  assign active      = in_cols && in_rows;
  assign cib_end     = (FW'(cib_r) + FW'(1)) >= f_r;
  assign rib_end     = (FW'(rib_r) + FW'(1)) >= f_r;
  assign first       = (cib_r == '0) && (rib_r == '0);
  assign last        = cib_end && rib_end;
  assign row_end     = (WW'(cc_r) + WW'(1)) >= w_r;
  assign frame_wrap  = (rc_r + HW'(1)) >= h_r;
  // Last block of the frame: no whole block follows to the right or below.
  assign frame_end   = active && last && !col_tail_ok && !row_tail_ok;

  // Raster position update.
  always_comb begin
    cc_nxt        = cc_r;
    rc_nxt        = rc_r;
    cib_nxt       = cib_r;
    rib_nxt       = rib_r;
    oc_nxt        = oc_r;
    col_start_nxt = col_start_r;
    row_start_nxt = row_start_r;
    if (acc) begin
      if (in_cols) begin
        if (cib_end) begin
          cib_nxt       = '0;
          oc_nxt        = oc_r + AW'(1);
          col_start_nxt = cc_r + AW'(1);
        end else begin
          cib_nxt = cib_r + BW'(1);
        end
      end
      cc_nxt = cc_r + AW'(1);
      if (row_end) begin
        cc_nxt        = '0;
        cib_nxt       = '0;
        oc_nxt        = '0;
        col_start_nxt = '0;
        rc_nxt        = rc_r + HW'(1);
        if (rib_end) begin
          rib_nxt       = '0;
          row_start_nxt = rc_r + HW'(1);
        end else begin
          rib_nxt = rib_r + BW'(1);
        end
        if (frame_wrap) begin
          rc_nxt        = '0;
          rib_nxt       = '0;
          row_start_nxt = '0;
        end
      end
    end
    if (cfg_hit) begin
      cc_nxt        = '0;
      rc_nxt        = '0;
      cib_nxt       = '0;
      rib_nxt       = '0;
      oc_nxt        = '0;
      col_start_nxt = '0;
      row_start_nxt = '0;
    end
  end

  // Configuration and position registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_r         <= FW'(1);
      w_r         <= WW'(W_RESET);
      h_r         <= HW'(4096);
      cc_r        <= '0;
      rc_r        <= '0;
      cib_r       <= '0;
      rib_r       <= '0;
      oc_r        <= '0;
      col_start_r <= '0;
      row_start_r <= '0;
    end else begin
      f_r         <= f_nxt;
      w_r         <= w_nxt;
      h_r         <= h_nxt;
      cc_r        <= cc_nxt;
      rc_r        <= rc_nxt;
      cib_r       <= cib_nxt;
      rib_r       <= rib_nxt;
      oc_r        <= oc_nxt;
      col_start_r <= col_start_nxt;
      row_start_r <= row_start_nxt;
    end
  end

  // Capture the request while its column sum is being read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
    end
    if (acc) begin
      s1_act_r   <= active;
      s1_first_r <= first;
      s1_last_r  <= last;
      s1_fend_r  <= frame_end;
      s1_addr_r  <= oc_r;
      s1_pix_r   <= in_pix.data;
    end
  end

  box_avg_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_WIDTH)
  ) u_sum_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr_r),
    .wdata (new_sum),
    .re    (acc),
    .raddr (oc_r),
    .rdata (ram_rdata)
  );

  // Forward the previous write when it went to the same column.
  assign base     = (lw_v_r && (lw_addr_r == s1_addr_r)) ? lw_data_r : ram_rdata;
  assign s1_ch[0] = s1_pix_r.red_in;
  assign s1_ch[1] = s1_pix_r.green_in;
  assign s1_ch[2] = s1_pix_r.blue_in;

  // Start a fresh sum on the first pixel of a block, otherwise accumulate.
  for (genvar c = 0; c < NUM_CH; c++) begin : g_acc
    assign new_sum[c] = s1_first_r ? SUM_W'(s1_ch[c])
                                   : base[c] + SUM_W'(s1_ch[c]);
  end

  assign wr_en = s1_v_r && s1_act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_v_r <= 1'b0;
    end else if (wr_en) begin
      lw_v_r <= 1'b1;
    end
    if (wr_en) begin
      lw_addr_r <= s1_addr_r;
      lw_data_r <= new_sum;
    end
  end

  // Finished block sums go to the mean unit.
  assign mean_req.valid     = s1_v_r && s1_act_r && s1_last_r;
  assign mean_req.frame_end = s1_fend_r;

  box_avg_mean #(
    .MAX_FACTOR (MAX_FACTOR)
  ) u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .factor    (f_r),
    .req       (mean_req),
    .sums      (new_sum),
    .res_valid (mres_valid),
    .res       (mres)
  );

  // Result queue.
  assign push          = mres_valid;
  assign pop           = out_res.valid && out_res.ready;
  assign out_res.valid = (cnt_r != '0);
  assign out_res.data  = fifo_mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + FCW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - FCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= wp_r + FAW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + FAW'(1);
      end
    end
    if (push) begin
      fifo_mem_r[wp_r] <= mres;
    end
  end

endmodule

`default_nettype wire

/* sim/box_avg_monitor.sv */
`timescale 1ns / 1ps
// Result checker for the box-average downscaler: watches the configuration
// port and both streams, predicts each block mean and compares it with the
// block's output. Depends on box_avg_pkg.
module box_avg_monitor
  import box_avg_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_FACTOR = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  pix_valid,
  input  logic                  pix_ready,
  input  pix_t                  pix_data,
  input  logic                  res_valid,
  input  logic                  res_ready,
  input  res_t                  res_data,
  output int                    error_count,
  output int                    pending
);

  // Register values after reset.
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 5'd1;
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd2048;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd4096;

  // Shadow copy of the configuration registers.
  logic [SCALE_W-1:0]  factor_reg;
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;

  // Per-column channel sums and the raster position.
  int unsigned column_sum [MAX_WIDTH][NUM_CH];
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned col_in_blk;
  int unsigned row_in_blk;
  int unsigned out_col;

  // Block means still owed by the block, oldest first.
  res_t mean_queue [$];
  int   errors;

  function automatic int unsigned block_side();
    int unsigned f;
    f = factor_reg;
    if (f == 0) f = 1;
    if (f > MAX_FACTOR) f = MAX_FACTOR;
    return f;
  endfunction

  function automatic int unsigned line_width();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned frame_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  task automatic restart_frame();
    col_pos    = 0;
    row_pos    = 0;
    col_in_blk = 0;
    row_in_blk = 0;
    out_col    = 0;
  endtask

  // A register write takes effect at once and starts a new frame; the
  // unused index is ignored and leaves the position alone.
  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
    bit known;
    known = 1'b1;
    case (idx)
      CFG_SCALE_FACTOR: factor_reg = value[SCALE_W-1:0];
      CFG_IMAGE_WIDTH:  width_reg  = value[WIDTH_W-1:0];
      CFG_IMAGE_HEIGHT: height_reg = value[HEIGHT_W-1:0];
      default:          known      = 1'b0;
    endcase
    if (known) restart_frame();
  endtask

  // Accumulate one pixel request and queue the block mean when it closes
  // a whole block.
  task automatic predict_block_mean(input pix_t p);
    int unsigned f, w, h, new_w, new_h, used_w, used_h, area;
    int unsigned chan [NUM_CH];
    int          c;
    bit          in_cols, in_rows, opens_block;
    res_t        mean;
    f      = block_side();
    w      = line_width();
    h      = frame_height();
    new_w  = w / f;
    new_h  = h / f;
    used_w = new_w * f;
    used_h = new_h * f;
    chan[0] = p.red_in;
    chan[1] = p.green_in;
    chan[2] = p.blue_in;
    in_cols = col_pos < used_w;
    in_rows = row_pos < used_h;

    if (in_cols && in_rows && out_col < MAX_WIDTH) begin
      opens_block = (col_in_blk == 0) && (row_in_blk == 0);
      for (c = 0; c < NUM_CH; c++) begin
        column_sum[out_col][c] = opens_block ? chan[c] : column_sum[out_col][c] + chan[c];
      end
      if (col_in_blk == f - 1 && row_in_blk == f - 1) begin
        area            = f * f;
        mean.red_mean   = 8'(column_sum[out_col][0] / area);
        mean.green_mean = 8'(column_sum[out_col][1] / area);
        mean.blue_mean  = 8'(column_sum[out_col][2] / area);
        mean.frame_end  = (row_pos == used_h - 1) && (out_col == new_w - 1);
        mean_queue.push_back(mean);
      end
    end

    // Advance the raster position; columns past the last whole block do
    // not move the block counters.
    if (in_cols) begin
      col_in_blk++;
      if (col_in_blk >= f) begin
        col_in_blk = 0;
        out_col++;
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos    = 0;
      col_in_blk = 0;
      out_col    = 0;
      row_in_blk++;
      if (row_in_blk >= f) row_in_blk = 0;
      row_pos++;
      if (row_pos >= h) begin
        row_pos    = 0;
        row_in_blk = 0;
      end
    end
  endtask

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic check_mean(input res_t got);
    res_t want;
    if (mean_queue.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      errors++;
    end else begin
      want = mean_queue.pop_front();
      compare_field("red_mean", want.red_mean, got.red_mean);
      compare_field("green_mean", want.green_mean, got.green_mean);
      compare_field("blue_mean", want.blue_mean, got.blue_mean);
      compare_field("frame_end", want.frame_end, got.frame_end);
    end
  endtask

  // Sample everything at the clock edge: configuration writes, then pixels, then results.
  always @(posedge clk) begin
    if (!rst_n) begin
      factor_reg = SCALE_RESET;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      restart_frame();
      mean_queue.delete();
      errors = 0;
    end else begin
      if (cfg_we) apply_write(cfg_index, cfg_data);
      if (pix_valid && pix_ready) predict_block_mean(pix_data);
      if (res_valid && res_ready) check_mean(res_data);
    end
    error_count <= errors;
    pending     <= mean_queue.size();
  end

endmodule

/* sim/box_average_downscaler_top_test.sv */
`timescale 1ns / 1ps
// Testbench top for the box-average downscaler: drives configuration and
// pixel requests, stalls the result side and reports the verdict.
// Depends on box_avg_pkg, box_avg_ifs, the block and box_avg_monitor.
module box_average_downscaler_top_test;
  import box_avg_pkg::*;

  localparam int MAX_WIDTH     = 2048;
  localparam int MAX_FACTOR    = 16;
  localparam int RANDOM_PIXELS = 350;
  localparam int DRAIN_CYCLES  = 10;
  localparam int HOLD_CYCLES   = 200;
  localparam int IDLE_PERCENT  = 30;
  localparam int RESET_CYCLES  = 12;
  localparam realtime TIMEOUT  = 10ms;

  // Index that maps to no register.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  // Pixel content styles.
  localparam int PIX_RANDOM   = 0;
  localparam int PIX_FULL     = 1;
  localparam int PIX_DARK     = 2;
  localparam int PIX_NEAR_MAX = 3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    error_count;
  int                    pending;
  bit                    calm;
  int                    hold_requests;
  int                    pixels_sent;

  box_avg_pix_if in_pix ();
  box_avg_res_if out_res ();

  box_average_downscaler_top #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_pix    (in_pix),
    .out_res   (out_res)
  );

  box_avg_monitor #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pix_valid   (in_pix.valid),
    .pix_ready   (in_pix.ready),
    .pix_data    (in_pix.data),
    .res_valid   (out_res.valid),
    .res_ready   (out_res.ready),
    .res_data    (out_res.data),
    .error_count (error_count),
    .pending     (pending)
  );

  // 50 MHz clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Result side: random stalls, one long hold-off per request from the
  // stimulus, and none at all during the calm phase.
  initial begin : receiver
    int hold_left;
    int holds_taken;
    hold_left     = 0;
    holds_taken   = 0;
    out_res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_res.ready <= 1'b0;
      end else if (holds_taken != hold_requests) begin
        holds_taken   = hold_requests;
        hold_left     = HOLD_CYCLES;
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT);
    $display("box_average_downscaler_top_test failed");
    $finish;
  end

  function automatic pix_t make_pixel(input int style);
    pix_t p;
    case (style)
      PIX_FULL: p = '1;
      PIX_DARK: p = '0;
      PIX_NEAR_MAX: begin
        p.red_in   = 8'(255 - $urandom_range(3));
        p.green_in = 8'(255 - $urandom_range(3));
        p.blue_in  = 8'(255 - $urandom_range(3));
      end
      default: begin
        p.red_in   = 8'($urandom);
        p.green_in = 8'($urandom);
        p.blue_in  = 8'($urandom);
      end
    endcase
    return p;
  endfunction

  // Offer one pixel request, with random gaps ahead of it outside the calm
  // phase, and return at the edge that accepts it.
  task automatic send_pixel(input pix_t p);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_pix.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_pix.valid <= 1'b1;
    in_pix.data  <= p;
    do @(posedge clk); while (!in_pix.ready);
    pixels_sent++;
  endtask

  // Stop offering, wait for every owed result, then let the pipeline empty.
  task automatic quiesce();
    in_pix.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  int unsigned cur_width;
  int unsigned cur_height;

  // Write the registers selected by the mask, optionally preceded by a
  // write to the unused index.
  task automatic configure(input bit [2:0] mask, input bit spare,
                           input int unsigned f, input int unsigned w,
                           input int unsigned h);
    if (spare) write_reg(CFG_SPARE_IDX, $urandom_range(0, 8191));
    if (mask[0]) begin
      write_reg(CFG_SCALE_FACTOR, f);
    end
    if (mask[1]) begin
      write_reg(CFG_IMAGE_WIDTH, w);
      cur_width = w;
    end
    if (mask[2]) begin
      write_reg(CFG_IMAGE_HEIGHT, h);
      cur_height = h;
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned f, input int unsigned w,
                           input int unsigned h, input int count, input int style);
    configure(3'b111, 1'b0, f, w, h);
    repeat (count) send_pixel(make_pixel(style));
    quiesce();
  endtask

  initial begin : stimulus
    int          random_start;
    int unsigned f, w, h, fw, fh, frame;
    int          count, style, pick;
    bit [2:0]    mask;
    bit          spare;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_SCALE_FACTOR;
    cfg_data      = '0;
    in_pix.valid  = 1'b0;
    in_pix.data   = '0;
    calm          = 1'b0;
    hold_requests = 0;
    pixels_sent   = 0;
    cur_width     = MAX_WIDTH;
    cur_height    = 4096;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One pixel per frame: every pixel is its own block and ends the frame.
    configure(3'b111, 1'b0, 1, 1, 1);
    send_pixel(pix_t'(24'h000000));
    send_pixel(pix_t'(24'hFFFFFF));
    send_pixel(pix_t'(24'hAA550F));
    quiesce();

    // A 2x2 block at full scale, then one whose mean truncates.
    configure(3'b111, 1'b0, 2, 2, 2);
    repeat (4) send_pixel(make_pixel(PIX_FULL));
    repeat (3) send_pixel(make_pixel(PIX_FULL));
    send_pixel(pix_t'(24'hFEFEFE));
    quiesce();

    // Zero factor, width and height all behave as one.
    configure(3'b111, 1'b1, 0, 0, 0);
    send_pixel(make_pixel(PIX_RANDOM));
    send_pixel(make_pixel(PIX_NEAR_MAX));
    quiesce();

    // Saturated factor wider than the image: no block is ever whole.
    configure(3'b111, 1'b0, 31, 3, 2);
    repeat (6) send_pixel(make_pixel(PIX_RANDOM));
    quiesce();

    // Width above the line store saturates to its size; only the start of
    // a line is sent.
    run_phase(1, 4095, 2, 100, PIX_RANDOM);

    // Largest factor: one block of full pixels, then an oversized factor
    // whose right column and bottom row are dropped.
    run_phase(16, 16, 16, 256, PIX_FULL);
    run_phase(20, 17, 17, 289, PIX_RANDOM);

    // Receiver holds off while pixels keep coming, so the block backs up.
    configure(3'b111, 1'b0, 1, 8, 8);
    hold_requests <= hold_requests + 1;
    repeat (64) send_pixel(make_pixel(PIX_RANDOM));
    quiesce();

    // A stretch with no idling on either side.
    calm <= 1'b1;
    run_phase(1, 16, 8, 128, PIX_RANDOM);
    calm <= 1'b0;

    // Random frames, mostly small, some cut short by the next write.
    random_start = pixels_sent;
    while (pixels_sent - random_start < RANDOM_PIXELS) begin
      pick = $urandom_range(99);
      if (pick < 70) f = $urandom_range(1, 4);
      else if (pick < 85) f = $urandom_range(5, 16);
      else if (pick < 92) f = 0;
      else f = $urandom_range(17, 31);
      pick = $urandom_range(99);
      if (pick < 80) w = $urandom_range(1, 24);
      else if (pick < 92) w = $urandom_range(25, 64);
      else w = 0;
      pick = $urandom_range(99);
      if (pick < 85) h = $urandom_range(1, 24);
      else if (pick < 92) h = 0;
      else h = $urandom_range(4096, 8191);
      mask  = ($urandom_range(99) < 80) ? 3'b111 : 3'($urandom_range(0, 7));
      spare = ($urandom_range(9) == 0);
      configure(mask, spare, f, w, h);

      fw    = (cur_width == 0) ? 1 : ((cur_width > MAX_WIDTH) ? MAX_WIDTH : cur_width);
      fh    = (cur_height == 0) ? 1 : cur_height;
      frame = fw * fh;
      if (frame > 400) count = $urandom_range(50, 400);
      else if ($urandom_range(2) == 0) count = $urandom_range(1, frame);
      else count = frame * $urandom_range(1, 2);
      style = ($urandom_range(99) < 80) ? PIX_RANDOM : $urandom_range(PIX_FULL, PIX_NEAR_MAX);

      repeat (count) send_pixel(make_pixel(style));
      quiesce();
    end

    if (error_count == 0 && pending == 0) begin
      $display("box_average_downscaler_top_test passed");
    end else begin
      $display("box_average_downscaler_top_test failed");
    end
    $finish;
  end

endmodule
